[design/bitmap_page_allocator_assert.svh]
// Assertion macros for the bitmap page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BPA_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define BPA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bpa_pkg.sv]
// Shared types and codes of the bitmap page allocator.
package bpa_pkg;

    localparam int PAGE_W     = 15;
    localparam int PAGE_SPAN  = 32768;
    localparam int MAX_BIT_W  = 6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [1:0]        status_t;

    // result of one word scan
    typedef struct packed {
        logic                 found;
        logic [MAX_BIT_W-1:0] bit_idx;
    } bpa_scan_t;

endpackage

[design/bpa_if.sv]
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if import bpa_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  op;
    page_t page_id;

    modport source (output valid, output op, output page_id, input ready);
    modport sink   (input valid, input op, input page_id, output ready);
endinterface

interface bpa_resp_if import bpa_pkg::*; ();
    logic    valid;
    logic    ready;
    page_t   page_id_out;
    status_t status;

    modport source (output valid, output page_id_out, output status, input ready);
    modport sink   (input valid, input page_id_out, input status, output ready);
endinterface

[design/bpa_map_ram.sv]
// Single-port free-map memory with registered read data.
module bpa_map_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

[design/bpa_page_split.sv]
// Splits a page number into map word, bit and word base (divide by word width).
module bpa_page_split import bpa_pkg::*; #(
    parameter int W     = 64,
    parameter int BIT_W = 6
) (
    input  logic             clk,
    input  logic             load,
    input  page_t            page_id,
    output page_t            word_idx,
    output page_t            word_base,
    output logic [BIT_W-1:0] bit_idx
);

    // reciprocal multiply, exact for 15-bit dividends and W up to 64
    localparam int SHIFT  = 22;
    localparam int RECIP  = ((1 << SHIFT) + W - 1) / W;
    localparam int PROD_W = PAGE_W + SHIFT;

    logic [PROD_W-1:0] prod_reg;
    page_t             pid_reg;
    page_t             quot;
    page_t             qbase;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(page_id) * PROD_W'(RECIP);
            pid_reg  <= page_id;
        end
    end

    assign quot  = prod_reg[SHIFT +: PAGE_W];
    assign qbase = PAGE_W'(quot * PAGE_W'(W));

    always_ff @(posedge clk)
    begin
        word_idx  <= quot;
        word_base <= qbase;
        bit_idx   <= BIT_W'(pid_reg - qbase);
    end

endmodule

[design/bpa_word_scan.sv]
// Lowest-free-bit search over one map word, with reserved and range masking.
module bpa_word_scan import bpa_pkg::*; #(
    parameter int W        = 64,
    parameter int BASE_W   = 16,
    parameter int RESERVED = 3,
    parameter int LIMIT    = 32768
) (
    input  logic [W-1:0]      word,
    input  logic [BASE_W-1:0] base,
    output logic [W-1:0]      low_mask,
    output bpa_scan_t         res
);

    logic [BASE_W:0] page;
    logic [W-1:0]    eff;

    always_comb
    begin
        page = '0;
        for (int b = 0; b < W; b++)
        begin
            page        = {1'b0, base} + (BASE_W+1)'(b);
            low_mask[b] = (32'(page) < RESERVED);
            eff[b]      = word[b] | low_mask[b] | (32'(page) >= LIMIT);
        end
    end

    // lowest clear bit wins
    always_comb
    begin
        res = '0;
        for (int b = W - 1; b >= 0; b--)
        begin
            if (!eff[b])
            begin
                res.found   = 1'b1;
                res.bit_idx = MAX_BIT_W'(b);
            end
        end
    end

endmodule

[design/bitmap_page_allocator.sv]
// Bitmap first-fit page allocator: sequencer, hint and result register.
//
// Requests arrive on req (op, page_id); one result word per request leaves on
// resp (page_id_out, status). A word moves when valid and ready are both high.
// op = alloc: the lowest free page at or above RESERVED_PAGES is marked used
// and returned (status allocated), or status full with page 0.
// op = free: the page's bit is cleared (pages beyond the store leave the map
// alone) and page_id is echoed with status freed.
// The map is a single-port memory of MAP_WORDS words. A first-fit hint word
// marks the lowest word that may hold a free page; frees pull it down.
// Sequence: a free of a page in the store goes through the word/bit split,
// the read, the write-back and the result; an alloc reads and scans words
// from the hint on, marks the page in the first word with a free page and
// writes that word back, then the result. The single memory port reads and
// writes a word in separate states. One request is in flight at a time: a
// new request is taken only after the last result has moved to the output reg.
// Reset: the map is swept one word per cycle, all MAP_WORDS words (512 at the
// defaults), with req.ready low; reserved pages end up used, all others free.
// Stall: a result waits in the output register while resp.ready is low; the
// next request is still taken and completes up to that register.
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int NUM_PAGES      = 32768,
    parameter int RESERVED_PAGES = 3,
    parameter int MAP_WORD_BITS  = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    bpa_req_if.sink         req,
    bpa_resp_if.source      resp
);

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (NUM_PAGES + W - 1) / W;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LIM_PAGES = (NUM_PAGES < PAGE_SPAN) ? NUM_PAGES : PAGE_SPAN;
    localparam int LIM_WORDS = (LIM_PAGES + W - 1) / W;
    localparam int CNT_W     = $clog2(LIM_WORDS + 1);
    localparam int BASE_W    = $clog2(MAP_WORDS * W + 1);
    localparam int BIT_W     = $clog2(W);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FREAD = 3'd3;
    localparam logic [2:0] S_FWAIT = 3'd4;
    localparam logic [2:0] S_AREAD = 3'd5;
    localparam logic [2:0] S_AWAIT = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [WORD_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  cur_word_reg, cur_word_next;
    logic [CNT_W-1:0]  hint_word_reg, hint_word_next;
    logic [BASE_W-1:0] hint_base_reg, hint_base_next;
    page_t             res_page_reg, res_page_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    page_t             out_page_reg, out_page_next;
    status_t           out_status_reg, out_status_next;

    logic               ram_wr;
    logic               ram_rd;
    logic [WORD_AW-1:0] ram_addr;
    logic [W-1:0]       ram_wdata;
    logic [W-1:0]       ram_rdata;

    logic               split_load;
    page_t              split_q;
    page_t              split_qbase;
    logic [BIT_W-1:0]   split_r;

    logic [W-1:0]       low_mask;
    bpa_scan_t          scan_res;

    bpa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW),
        .DW    (W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .rd_en   (ram_rd),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    bpa_page_split #(
        .W     (W),
        .BIT_W (BIT_W)
    ) u_split (
        .clk       (clk),
        .load      (split_load),
        .page_id   (req.page_id),
        .word_idx  (split_q),
        .word_base (split_qbase),
        .bit_idx   (split_r)
    );

    // the same base register drives the reset pattern during the sweep
    bpa_word_scan #(
        .W        (W),
        .BASE_W   (BASE_W),
        .RESERVED (RESERVED_PAGES),
        .LIMIT    (LIM_PAGES)
    ) u_scan (
        .word     (ram_rdata),
        .base     (base_reg),
        .low_mask (low_mask),
        .res      (scan_res)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign resp.valid       = out_valid_reg;
    assign resp.page_id_out = out_page_reg;
    assign resp.status      = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        base_next       = base_reg;
        cur_word_next   = cur_word_reg;
        hint_word_next  = hint_word_reg;
        hint_base_next  = hint_base_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        ram_wr          = 1'b0;
        ram_rd          = 1'b0;
        ram_addr        = WORD_AW'(cur_word_reg);
        ram_wdata       = ram_rdata;
        split_load      = 1'b0;

        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr       = 1'b1;
                ram_addr     = clr_idx_reg;
                ram_wdata    = low_mask;
                base_next    = base_reg + BASE_W'(W);
                clr_idx_next = clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == MAP_WORDS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_FREE)
                    begin
                        res_page_next   = req.page_id;
                        res_status_next = ST_FREED;
                        if (32'(req.page_id) < NUM_PAGES)
                        begin
                            split_load = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    else
                    begin
                        cur_word_next = hint_word_reg;
                        base_next     = hint_base_reg;
                        state_next    = S_AREAD;
                    end
                end
            end
            S_DIV:
            begin
                state_next = S_FREAD;
            end
            S_FREAD:
            begin
                ram_rd     = 1'b1;
                ram_addr   = WORD_AW'(split_q);
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                ram_wr    = 1'b1;
                ram_addr  = WORD_AW'(split_q);
                ram_wdata = ram_rdata & ~(W'(1) << split_r);
                if (CNT_W'(split_q) < hint_word_reg)
                begin
                    hint_word_next = CNT_W'(split_q);
                    hint_base_next = BASE_W'(split_qbase);
                end
                state_next = S_PUSH;
            end
            S_AREAD:
            begin
                if (32'(cur_word_reg) == LIM_WORDS)
                begin
                    res_page_next   = '0;
                    res_status_next = ST_FULL;
                    state_next      = S_PUSH;
                end
                else
                begin
                    ram_rd     = 1'b1;
                    state_next = S_AWAIT;
                end
            end
            S_AWAIT:
            begin
                if (scan_res.found)
                begin
                    ram_wr          = 1'b1;
                    ram_wdata       = ram_rdata | (W'(1) << scan_res.bit_idx);
                    res_page_next   = PAGE_W'(base_reg + BASE_W'(scan_res.bit_idx));
                    res_status_next = ST_ALLOCATED;
                    state_next      = S_PUSH;
                end
                else
                begin
                    // word is full: everything below the next word is full
                    cur_word_next  = cur_word_reg + 1'b1;
                    base_next      = base_reg + BASE_W'(W);
                    hint_word_next = cur_word_reg + 1'b1;
                    hint_base_next = base_reg + BASE_W'(W);
                    state_next     = S_AREAD;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = res_page_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            base_reg      <= '0;
            cur_word_reg  <= '0;
            hint_word_reg <= '0;
            hint_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            base_reg      <= base_next;
            cur_word_reg  <= cur_word_next;
            hint_word_reg <= hint_word_next;
            hint_base_reg <= hint_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    `BPA_CHECK(a_clear_blocks_req, state_reg == S_CLEAR, !req.ready, "request taken during map sweep")
    `BPA_CHECK(a_alloc_in_range, resp.valid && resp.status == ST_ALLOCATED, (32'(resp.page_id_out) >= RESERVED_PAGES) && (32'(resp.page_id_out) < LIM_PAGES), "allocated page out of range")
    `BPA_CHECK(a_full_page_zero, resp.valid && resp.status == ST_FULL, resp.page_id_out == '0, "full result with non-zero page")
    `BPA_CHECK(a_hint_bounded, state_reg != S_CLEAR, 32'(hint_word_reg) <= LIM_WORDS, "hint word beyond search range")
    `BPA_CHECK_NEXT(a_push_loads_out, state_reg == S_PUSH && (!out_valid_reg || resp.ready), out_valid_reg, "result not loaded into output register")

endmodule
